>>> hdl/sha512c_pkg.sv
// ============================================================================
// SHA-512 compression package
// Shared types, sizes, state encoding and constant tables for the SHA-512
// compression block.
// ============================================================================
package sha512c_pkg;

  localparam int unsigned ROUNDS       = 80;
  localparam int unsigned BLOCK_WORDS  = 16;
  localparam int unsigned DIGEST_WORDS = 8;
  localparam int unsigned WORD_W       = 64;
  localparam int unsigned RND_W        = $clog2(ROUNDS);
  localparam int unsigned CNT_W        = $clog2(BLOCK_WORDS);
  localparam int unsigned IDX_W        = $clog2(DIGEST_WORDS);

  // Initial value selection, as written to the variant register.
  localparam logic VARIANT_512 = 1'b0;
  localparam logic VARIANT_384 = 1'b1;

  typedef logic [WORD_W-1:0]                     word_t;
  typedef logic [DIGEST_WORDS-1:0][WORD_W-1:0]   wv_t;
  typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0]    sched_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FIN,
    ST_OUT
  } state_t;

  function automatic word_t round_k(input logic [RND_W-1:0] t);
    word_t k;
    case (t)
      7'd0:  k = 64'h428a2f98d728ae22;
      7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;
      7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;
      7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;
      7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;
      7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;
      7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;
      7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;
      7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;
      7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;
      7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;
      7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;
      7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;
      7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;
      7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;
      7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;
      7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;
      7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;
      7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;
      7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;
      7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;
      7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;
      7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;
      7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;
      7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;
      7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;
      7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;
      7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;
      7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;
      7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;
      7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;
      7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;
      7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;
      7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;
      7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;
      7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;
      7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;
      7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;
      7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;
      7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;
      7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t iv_word(input logic sel, input logic [IDX_W-1:0] idx);
    word_t v;
    if (sel == VARIANT_384) begin
      case (idx)
        3'd0: v = 64'hcbbb9d5dc1059ed8;
        3'd1: v = 64'h629a292a367cd507;
        3'd2: v = 64'h9159015a3070dd17;
        3'd3: v = 64'h152fecd8f70e5939;
        3'd4: v = 64'h67332667ffc00b31;
        3'd5: v = 64'h8eb44a8768581511;
        3'd6: v = 64'hdb0c2e0d64f98fa7;
        default: v = 64'h47b5481dbefa4fa4;
      endcase
    end else begin
      case (idx)
        3'd0: v = 64'h6a09e667f3bcc908;
        3'd1: v = 64'hbb67ae8584caa73b;
        3'd2: v = 64'h3c6ef372fe94f82b;
        3'd3: v = 64'ha54ff53a5f1d36f1;
        3'd4: v = 64'h510e527fade682d1;
        3'd5: v = 64'h9b05688c2b3e6c1f;
        3'd6: v = 64'h1f83d9abfb41bd6b;
        default: v = 64'h5be0cd19137e2179;
      endcase
    end
    return v;
  endfunction

endpackage

>>> hdl/sha512c_ifs.sv
// ============================================================================
// SHA-512 compression channels
// Valid/ready channel interfaces for message words in and digest words out.
// ============================================================================
interface sha512c_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic        first_block;

  modport source (output valid, output message_word, output first_block, input ready);
  modport sink   (input valid, input message_word, input first_block, output ready);
endinterface

interface sha512c_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

>>> hdl/sha512c_round.sv
// ============================================================================
// SHA-512 round datapath
// One compression round on the working variables and one step of the
// message schedule expansion over a sliding 16-word window.
// ============================================================================
module sha512c_round import sha512c_pkg::*; (
  input  wv_t    wv,
  input  sched_t sched,
  input  word_t  k,
  output wv_t    wv_next,
  output word_t  sched_next
);

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  word_t big_s0, big_s1, ch, maj, t1, t2;

  always_comb begin
    big_s1 = rotr(wv[4], 14) ^ rotr(wv[4], 18) ^ rotr(wv[4], 41);
    big_s0 = rotr(wv[0], 28) ^ rotr(wv[0], 34) ^ rotr(wv[0], 39);
    ch     = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    maj    = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t1     = wv[7] + big_s1 + ch + k + sched[0];
    t2     = big_s0 + maj;

    wv_next[0] = t1 + t2;
    wv_next[1] = wv[0];
    wv_next[2] = wv[1];
    wv_next[3] = wv[2];
    wv_next[4] = wv[3] + t1;
    wv_next[5] = wv[4];
    wv_next[6] = wv[5];
    wv_next[7] = wv[6];
  end

  // The window holds W[t..t+15]; this produces W[t+16].
  assign sched_next = (rotr(sched[14], 19) ^ rotr(sched[14], 61) ^ (sched[14] >> 6))
                    + sched[9]
                    + (rotr(sched[1], 1) ^ rotr(sched[1], 8) ^ (sched[1] >> 7))
                    + sched[0];

endmodule

>>> hdl/sha512_compression.sv
// ============================================================================
// SHA-512 compression function
// Collects 16 padded 64-bit message words per block, runs the 80 rounds and
// emits the 8 updated chaining words.
// ============================================================================
// Usage:
// Message words arrive on in_ch, one transaction per 64-bit word, big-endian
// within the 1024-bit block. Set first_block on the first word of a message;
// that reloads the initial value chosen by the variant register (cfg_we and
// cfg_wdata, 0 for SHA-512, 1 for SHA-384) and restarts the word count.
// While collecting, a word is taken every cycle. The 16th word starts the
// compression: the rounds run one per cycle, then a finalize step adds the
// first chaining word and the first digest word is shown on out_ch. The
// remaining seven words follow one per cycle as long as out_ch.ready stays
// high, which the chaining memory's one read per cycle allows.
// No word is taken from the moment the compression starts until the last
// digest word has been taken. If the receiver stalls, the current digest
// word holds and the block simply waits. Reset returns to collection with
// an empty block, the SHA-512 initial value and variant 0.
// ============================================================================
module sha512_compression import sha512c_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  sha512c_in_if.sink    in_ch,
  sha512c_out_if.source out_ch,
  input  logic  cfg_we,
  input  logic  cfg_wdata
);

  // Control registers.
  state_t             state_r, state_nxt;
  logic               variant_r;
  logic               use_iv_r, use_iv_nxt;    // chaining value is the initial value
  logic               iv_sel_r, iv_sel_nxt;    // which initial value applies
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [RND_W-1:0]   rnd_r, rnd_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  // Payload registers.
  wv_t                wv_r, wv_nxt;
  sched_t             sched_r, sched_nxt;
  word_t              digest_r, digest_nxt;

  // Chaining value memory, one read and one write port, registered read.
  word_t              cv_mem [DIGEST_WORDS];
  word_t              rd_data_r;
  logic [IDX_W-1:0]   rd_addr;

  // Decoded controls.
  logic               in_ready;
  logic               out_valid;
  logic               in_acc;
  logic               out_acc;
  logic               is_last;
  logic               fin_we;
  logic [IDX_W-1:0]   fin_idx;
  logic [CNT_W-1:0]   base_cnt;
  logic               launch;
  word_t              fin_base;
  word_t              fin_sum;

  wv_t                rnd_wv;
  word_t              rnd_w;

  sha512c_round u_round (
    .wv         (wv_r),
    .sched      (sched_r),
    .k          (round_k(rnd_r)),
    .wv_next    (rnd_wv),
    .sched_next (rnd_w)
  );

  assign in_acc   = in_ch.valid && in_ready;
  assign out_acc  = out_valid && out_ch.ready;
  assign is_last  = (idx_r == IDX_W'(DIGEST_WORDS - 1));
  // A first_block word always starts over at word zero of a fresh block.
  assign base_cnt = in_ch.first_block ? '0 : cnt_r;
  assign launch   = (base_cnt == CNT_W'(BLOCK_WORDS - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && launch) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd_r == RND_W'(ROUNDS - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc && is_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs. The finalize step adds one chaining word and writes it
  // back; in ST_OUT the next word is done as soon as the current one leaves.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    fin_we    = 1'b0;
    fin_idx   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_ROUND: begin
      end
      ST_FIN: begin
        fin_we = 1'b1;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        fin_we    = out_acc && !is_last;
        fin_idx   = idx_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The memory read runs one word ahead of the adder: during the rounds it
  // fetches word zero, afterwards the word after the one being written.
  assign rd_addr  = (state_r == ST_ROUND) ? idx_r : IDX_W'(idx_nxt + 1'b1);
  assign fin_base = use_iv_r ? iv_word(iv_sel_r, fin_idx) : rd_data_r;
  assign fin_sum  = fin_base + wv_r[0];

  // Datapath and counters.
  always_comb begin
    use_iv_nxt = use_iv_r;
    iv_sel_nxt = iv_sel_r;
    cnt_nxt    = cnt_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    wv_nxt     = wv_r;
    sched_nxt  = sched_r;
    digest_nxt = digest_r;

    if (in_acc) begin
      if (in_ch.first_block) begin
        use_iv_nxt = 1'b1;
        iv_sel_nxt = variant_r;
      end
      cnt_nxt   = base_cnt + 1'b1;
      sched_nxt = {in_ch.message_word, sched_r[BLOCK_WORDS-1:1]};
      if (launch) begin
        rnd_nxt = '0;
        idx_nxt = '0;
        // Working variables start from the chaining value. After a finished
        // block they already hold it; after a reload they take the constant.
        if (use_iv_r) begin
          for (int i = 0; i < DIGEST_WORDS; i++) begin
            wv_nxt[i] = iv_word(iv_sel_r, IDX_W'(i));
          end
        end
      end
    end

    if (state_r == ST_ROUND) begin
      wv_nxt    = rnd_wv;
      sched_nxt = {rnd_w, sched_r[BLOCK_WORDS-1:1]};
      rnd_nxt   = rnd_r + 1'b1;
    end

    if (state_r == ST_OUT && out_acc && !is_last) begin
      idx_nxt = idx_r + 1'b1;
    end

    // Rotate the working variables so that the one to add is always at
    // position zero; after eight steps they hold the new chaining value.
    if (fin_we) begin
      wv_nxt     = {fin_sum, wv_r[DIGEST_WORDS-1:1]};
      digest_nxt = fin_sum;
      if (fin_idx == IDX_W'(DIGEST_WORDS - 1)) use_iv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      variant_r <= VARIANT_512;
      use_iv_r  <= 1'b1;
      iv_sel_r  <= VARIANT_512;
      cnt_r     <= '0;
      rnd_r     <= '0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      use_iv_r  <= use_iv_nxt;
      iv_sel_r  <= iv_sel_nxt;
      cnt_r     <= cnt_nxt;
      rnd_r     <= rnd_nxt;
      idx_r     <= idx_nxt;
      if (cfg_we) variant_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    wv_r     <= wv_nxt;
    sched_r  <= sched_nxt;
    digest_r <= digest_nxt;
  end

  always_ff @(posedge clk) begin
    if (fin_we) cv_mem[fin_idx] <= fin_sum;
    rd_data_r <= cv_mem[rd_addr];
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.digest_word = digest_r;
  assign out_ch.word_index  = idx_r;
  assign out_ch.last_word   = is_last;

endmodule

>>> hdl/sha512c_checker.sv
// ============================================================================
// SHA-512 compression checker
// Port-level checks on the ordering of input and digest transactions.
// ============================================================================
module sha512c_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_word,
  input logic [2:0]  out_index,
  input logic        out_last
);

  // No message word is taken while digest words are pending.
  a_no_input_while_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("message word accepted while digest words pending");

  // A taken message word is never followed directly by a digest word.
  a_no_output_after_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid)
    else $error("digest word shown right after a message word");

  // Digest words come out in order with no gap in the index.
  a_index_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && out_index == 3'($past(out_index) + 3'd1)))
    else $error("digest word index did not advance");

  // Taking the last digest word returns the block to collecting words.
  a_back_to_collect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> (in_ready && !out_valid))
    else $error("block not ready for words after last digest word");

  // A stalled digest transaction holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word) && $stable(out_index)))
    else $error("digest transaction changed while stalled");

endmodule

bind sha512_compression sha512c_checker u_sha512c_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.digest_word),
  .out_index (out_ch.word_index),
  .out_last  (out_ch.last_word)
);

>>> dv/sha512_digest_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// SHA-512 digest checker
// Watches the message and digest channels and the variant register, keeps
// its own copy of the hash state, and compares every digest word with the
// value it computes.
// ============================================================================
module sha512_digest_checker import sha512c_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  word_t            in_word,
  input  logic             in_first,
  input  logic             out_valid,
  input  logic             out_ready,
  input  word_t            out_word,
  input  logic [IDX_W-1:0] out_index,
  input  logic             out_last,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  output int               mismatch_count,
  output int               digests_pending
);

  typedef struct {
    word_t            value;
    logic [IDX_W-1:0] index;
    logic             last;
  } digest_word_t;

  localparam word_t ROUND_K [ROUNDS] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam word_t IV_SHA512 [DIGEST_WORDS] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t IV_SHA384 [DIGEST_WORDS] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  logic             iv_select;
  word_t            hash_state [DIGEST_WORDS];
  word_t            msg_block [BLOCK_WORDS];
  logic [CNT_W-1:0] words_held;
  digest_word_t     digest_q [$];
  int               fail_total = 0;

  function automatic word_t ror64(word_t x, int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t upper_sum0(word_t x);
    return ror64(x, 28) ^ ror64(x, 34) ^ ror64(x, 39);
  endfunction

  function automatic word_t upper_sum1(word_t x);
    return ror64(x, 14) ^ ror64(x, 18) ^ ror64(x, 41);
  endfunction

  function automatic word_t sched_mix0(word_t x);
    return ror64(x, 1) ^ ror64(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t sched_mix1(word_t x);
    return ror64(x, 19) ^ ror64(x, 61) ^ (x >> 6);
  endfunction

  function automatic void load_iv(logic sel);
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      hash_state[i] = (sel == VARIANT_384) ? IV_SHA384[i] : IV_SHA512[i];
    end
  endfunction

  // Eighty rounds over the collected block; the schedule is expanded in place
  // in a 16-entry window, then the eight updated state words are queued.
  function automatic void compress_block();
    word_t        v [DIGEST_WORDS];
    word_t        w;
    word_t        t1;
    word_t        t2;
    digest_word_t d;
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      v[i] = hash_state[i];
    end
    for (int t = 0; t < ROUNDS; t++) begin
      if (t < BLOCK_WORDS) begin
        w = msg_block[t];
      end else begin
        w = sched_mix1(msg_block[(t - 2) % BLOCK_WORDS]) + msg_block[(t - 7) % BLOCK_WORDS]
            + sched_mix0(msg_block[(t - 15) % BLOCK_WORDS]) + msg_block[t % BLOCK_WORDS];
        msg_block[t % BLOCK_WORDS] = w;
      end
      t1 = v[7] + upper_sum1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w;
      t2 = upper_sum0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      hash_state[i] = hash_state[i] + v[i];
      d.value = hash_state[i];
      d.index = IDX_W'(i);
      d.last  = (i == DIGEST_WORDS - 1);
      digest_q.push_back(d);
    end
  endfunction

  function automatic void absorb_word(word_t w, logic first);
    if (first) begin
      load_iv(iv_select);
      words_held = '0;
    end
    msg_block[words_held] = w;
    words_held = words_held + 1'b1;
    if (words_held == '0) begin
      compress_block();
    end
  endfunction

  function automatic void check_digest();
    digest_word_t want;
    if (digest_q.size() == 0) begin
      fail_total++;
      if (fail_total <= 10) begin
        $display("[%0t] unexpected digest word %h index %0d last %0b",
                 $time, out_word, out_index, out_last);
      end
    end else begin
      want = digest_q.pop_front();
      if (out_word !== want.value || out_index !== want.index || out_last !== want.last) begin
        fail_total++;
        if (fail_total <= 10) begin
          $display("[%0t] digest mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                   $time, want.value, want.index, want.last, out_word, out_index, out_last);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      iv_select = VARIANT_512;
      load_iv(VARIANT_512);
      words_held = '0;
      digest_q.delete();
    end else begin
      if (cfg_we) begin
        iv_select = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        absorb_word(in_word, in_first);
      end
      if (out_valid && out_ready) begin
        check_digest();
      end
    end
    mismatch_count  <= fail_total;
    digests_pending <= digest_q.size();
  end

endmodule

>>> dv/tb_sha512_compression.sv
`timescale 1ns / 1ps
// ============================================================================
// SHA-512 compression testbench
// Feeds message words in bursts, runs multi-block messages, truncated
// messages and stray words under both initial-value settings, stalls the
// digest side, and lets a separate checker compare every digest word.
// ============================================================================
module tb_sha512_compression;
  import sha512c_pkg::*;

  localparam int RANDOM_ITEMS  = 340;
  localparam int PHASES        = 4;
  // Length of the one long receiver hold-off; far longer than a block takes
  // to fill and compress, so the input side is certain to back up.
  localparam int HOLD_CYCLES   = 400;
  // Cycles with no transaction on either channel before the run is declared
  // hung. The longest quiet stretch in a correct run is the hold-off above
  // plus one compression plus a sender gap, well under this.
  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 8;
  // Tail after the last digest word: a bit more than a whole block's latency,
  // so a stray extra result would still show up.
  localparam int TAIL_CYCLES   = 120;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  sha512c_in_if  in_ch ();
  sha512c_out_if out_ch ();

  int mismatch_count;
  int digests_pending;

  // Sender bookkeeping: words accepted so far, words left in the current
  // burst, and a switch that turns the gaps between bursts off.
  int words_sent  = 0;
  int burst_left  = 0;
  bit steady_feed = 1'b0;

  sha512_compression dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sha512_digest_checker digest_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_word         (in_ch.message_word),
    .in_first        (in_ch.first_block),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_word        (out_ch.digest_word),
    .out_index       (out_ch.word_index),
    .out_last        (out_ch.last_word),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .digests_pending (digests_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Message words are mostly random, with a share of all-zero, all-one and
  // single-bit patterns so the adders and rotators see their corner values.
  function automatic word_t rand_word();
    word_t w;
    case ($urandom_range(0, 11))
      0: w = '0;
      1: w = '1;
      2: w = word_t'(1) << $urandom_range(0, WORD_W - 1);
      3: w = ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
      default: w = {$urandom(), $urandom()};
    endcase
    return w;
  endfunction

  // Offers one word and returns at the edge where the transaction completes.
  // A new burst may start with a gap; valid is only lowered when there is a
  // gap, so it never drops and rises again in the same time step.
  task automatic offer_word(input word_t w, input logic first);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady_feed || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.message_word <= w;
    in_ch.first_block  <= first;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    words_sent++;
  endtask

  // Stops offering and waits until every predicted digest word has come
  // back. Words that complete no block leave nothing running, so a short
  // settle is enough before the variant register may be touched.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (digests_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_variant(input logic sel);
    cfg_we    <= 1'b1;
    cfg_wdata <= sel;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One message. Most are well formed: first_block on word 0 and one to
  // three whole blocks, which exercises chaining across blocks. Some are cut
  // short, so the next message's first_block lands in mid-block and must
  // drop the partial block. A few are loose words with first_block at random.
  // A message never runs past the words left in the phase.
  task automatic send_message(input int budget);
    int kind;
    int nwords;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      nwords = BLOCK_WORDS * $urandom_range(1, 3);
    end else if (kind < 9) begin
      nwords = BLOCK_WORDS * $urandom_range(0, 1) + $urandom_range(1, BLOCK_WORDS - 1);
    end else begin
      nwords = $urandom_range(1, 4);
    end
    if (nwords > budget) begin
      nwords = budget;
    end
    for (int i = 0; i < nwords; i++) begin
      if (kind == 9) begin
        offer_word(rand_word(), $urandom_range(0, 3) == 0);
      end else begin
        offer_word(rand_word(), i == 0);
      end
    end
    // Now and then the sender holds back until the digest side has caught up.
    if ($urandom_range(0, 11) == 0) begin
      wait_drained();
    end
  endtask

  // Receiver: ready follows a pattern that changes at random intervals
  // (always ready, coin flip, mostly stalled, alternating). Once, after a few
  // blocks, it holds ready low for a long stretch while a digest word waits,
  // so the block stops taking words and the sender is left offering.
  initial begin : receiver
    int taken;
    int seg_left;
    int mode;
    bit held_off;
    taken    = 0;
    seg_left = 0;
    mode     = 0;
    held_off = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        taken++;
      end
      if (!held_off && taken >= 24 && out_ch.valid === 1'b1) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 120);
        end
        seg_left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= !out_ch.ready;
        endcase
      end
    end
  end

  // Watchdog: any transaction on either channel restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int phase_start;
    // Every input of the block is known from time zero.
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.message_word <= '0;
    in_ch.first_block  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_variant(VARIANT_512);

    // Directed part. The first block goes in without first_block, so it
    // starts from the chaining value that reset leaves, and its words cover
    // the extremes and alternating patterns.
    offer_word(64'h0000000000000000, 1'b0);
    offer_word(64'hffffffffffffffff, 1'b0);
    offer_word(64'h0000000000000001, 1'b0);
    offer_word(64'h8000000000000000, 1'b0);
    offer_word(64'h5555555555555555, 1'b0);
    offer_word(64'haaaaaaaaaaaaaaaa, 1'b0);
    offer_word(64'h7fffffffffffffff, 1'b0);
    offer_word(64'hfffffffffffffffe, 1'b0);
    offer_word(64'h0123456789abcdef, 1'b0);
    offer_word(64'hfedcba9876543210, 1'b0);
    offer_word(64'h00000000ffffffff, 1'b0);
    offer_word(64'hffffffff00000000, 1'b0);
    offer_word(64'h8000000000000000, 1'b0);
    offer_word(64'h0000000000000000, 1'b0);
    offer_word(64'h0000000000000000, 1'b0);
    offer_word(64'h0000000000000400, 1'b0);
    // A few words of a second block, then first_block in mid-block: the
    // partial block is dropped and the initial value reloaded.
    offer_word(64'hffffffffffffffff, 1'b0);
    offer_word(64'h0000000000000000, 1'b0);
    offer_word(64'hdeadbeefcafef00d, 1'b0);
    offer_word(64'h6162638000000000, 1'b1);
    wait_drained();

    // Random part in phases that alternate the initial-value setting; the
    // register is only written once all digest words are back. The third
    // phase feeds words back to back with no gaps.
    for (int p = 0; p < PHASES; p++) begin
      write_variant((p % 2 == 0) ? VARIANT_384 : VARIANT_512);
      steady_feed = (p == 2);
      phase_start = words_sent;
      while (words_sent - phase_start < RANDOM_ITEMS / PHASES) begin
        send_message(RANDOM_ITEMS / PHASES - (words_sent - phase_start));
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
